@@ rtl/prim_minimum_spanning_tree_core_defines.svh @@
// ---------------------------------------------------------------------------
// prim_minimum_spanning_tree_core_defines.svh
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef PRIM_MINIMUM_SPANNING_TREE_CORE_DEFINES_SVH
`define PRIM_MINIMUM_SPANNING_TREE_CORE_DEFINES_SVH

// same-cycle implication
`define PMST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("prim mst check failed");

// next-cycle implication
`define PMST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("prim mst check failed");

`endif

@@ rtl/prim_mst_pkg.sv @@
// ---------------------------------------------------------------------------
// prim_mst_pkg
// shared constants and types of the minimum spanning tree core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prim_mst_pkg;

  localparam int unsigned KEY_W = 14;
  localparam logic [KEY_W-1:0] WEIGHT_LIMIT = 14'd10000;

  localparam int unsigned VNUM_W = 6;
  localparam logic [VNUM_W-1:0] VCOUNT_RST = 6'd32;

  localparam int unsigned OUT_TDATA_W = 16;

  typedef struct packed {
    logic [VNUM_W-1:0] low_vertex;
    logic [VNUM_W-1:0] high_vertex;
    logic              last_edge;
    logic              disconnected;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/prim_minimum_spanning_tree_core.sv @@
// ---------------------------------------------------------------------------
// prim_minimum_spanning_tree_core
// loads an adjacency matrix, runs prim from vertex 0, emits sorted tree edges
// ---------------------------------------------------------------------------
// load: one weight per cycle while no register write is pending, v*v weights;
// prim: up to v-1 passes over the weight and vertex memories (one read of each
// per cycle), or one disconnected result if the graph is not connected; output
// scan reads and captures each row, then reads and checks each vertex pair,
// stalled by the result stage. reset clears control state and sets v to 32;
// the memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module prim_minimum_spanning_tree_core
  import prim_mst_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned WEIGHT_WIDTH = 14
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [VNUM_W-1:0]                     cfg_data_i,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [((WEIGHT_WIDTH+7)/8)*8-1:0]     s_axis_tdata,   // weight
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic      [OUT_TDATA_W-1:0]                m_axis_tdata,   // low_vertex, high_vertex
  output logic                                       m_axis_tlast,   // last_edge
  output logic                                       m_axis_tuser    // disconnected
);

  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = KEY_W + 2 * VW;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS,
    ST_DECIDE,
    ST_ROW_RD,
    ST_ROW_CAP,
    ST_PAIR_RD,
    ST_PAIR_CHK
  } state_e;

  state_e                  state_q, state_d;
  logic [VNUM_W-1:0]       vcount_q, vcount_d;
  logic [AW-1:0]           load_pos_q, load_pos_d;
  logic [MAX_VERTICES-1:0] in_tree_q, in_tree_d;
  logic [CW-1:0]           size_q, size_d;
  logic [VW-1:0]           u_q, u_d;
  logic [VW-1:0]           r_q, r_d;
  logic [AW-1:0]           base_q, base_d;
  logic                    first_q, first_d;
  logic [CW-1:0]           c_q, c_d;
  logic [VW-1:0]           cd_q;
  logic                    proc_q, proc_d;
  logic [KEY_W-1:0]        best_key_q, best_key_d;
  logic [VW-1:0]           best_rank_q, best_rank_d;
  logic [VW-1:0]           best_c_q, best_c_d;
  logic [VW-1:0]           lo_q, lo_d;
  logic [VW-1:0]           hi_q, hi_d;
  logic [VW-1:0]           plo_q, plo_d;
  logic [CW-1:0]           ecnt_q, ecnt_d;

  logic [CW-1:0]   vnum;
  logic [AW:0]     total;
  logic            s_acc;
  logic            last_load;

  logic            wre;
  logic [KEY_W-1:0] w_rd;

  logic            vre, vwe;
  logic [VW-1:0]   vraddr;
  logic [DW-1:0]   vrd, vwdata;
  logic [KEY_W-1:0] old_key, new_key;
  logic [VW-1:0]   old_par, old_rank, new_par, new_rank, rd_par;
  logic            upd, out_tree, better;

  logic            found, edge_hit, is_last;
  logic            out_valid, out_ready;
  out_item_t       out_item;

  always_comb begin
    if (vcount_q == '0) begin
      vnum = CW'(1);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      vnum = CW'(MAX_VERTICES);
    end else begin
      vnum = CW'(vcount_q);
    end
  end

  assign total       = (AW + 1)'(vnum) * (AW + 1)'(vnum);
  assign last_load   = {1'b0, load_pos_q} == (total - (AW + 1)'(1));
  // a register write takes the cycle, the weight waits
  assign s_axis_tready = (state_q == ST_LOAD) && !cfg_valid_i;
  assign s_acc       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = (state_q == ST_LOAD);

  // pass datapath
  assign rd_par   = vrd[2*VW-1:VW];
  assign old_key  = first_q ? WEIGHT_LIMIT : vrd[DW-1:2*VW];
  assign old_par  = rd_par;
  assign old_rank = vrd[VW-1:0];
  assign upd      = w_rd < old_key;
  assign new_key  = upd ? w_rd : old_key;
  assign new_par  = upd ? u_q : old_par;
  assign new_rank = upd ? r_q : old_rank;
  assign out_tree = !in_tree_q[cd_q];
  assign vwe      = proc_q && out_tree;
  assign vwdata   = {new_key, new_par, new_rank};
  assign better   = proc_q && out_tree && (new_key < WEIGHT_LIMIT) &&
                    ((new_key < best_key_q) ||
                     ((new_key == best_key_q) && (new_rank < best_rank_q)));

  assign wre = (state_q == ST_PASS) && (c_q < vnum);

  always_comb begin
    vre    = 1'b0;
    vraddr = c_q[VW-1:0];
    case (state_q)
      ST_PASS: begin
        vre = c_q < vnum;
      end
      ST_ROW_RD: begin
        vre    = 1'b1;
        vraddr = lo_q;
      end
      ST_PAIR_RD: begin
        vre    = 1'b1;
        vraddr = hi_q;
      end
      default: begin
        vre = 1'b0;
      end
    endcase
  end

  assign found    = best_key_q < WEIGHT_LIMIT;
  assign edge_hit = (rd_par == lo_q) || ((lo_q != '0) && (plo_q == hi_q));
  assign is_last  = ecnt_q == (vnum - CW'(2));

  always_comb begin
    state_d     = state_q;
    vcount_d    = vcount_q;
    load_pos_d  = load_pos_q;
    in_tree_d   = in_tree_q;
    size_d      = size_q;
    u_d         = u_q;
    r_d         = r_q;
    base_d      = base_q;
    first_d     = first_q;
    c_d         = c_q;
    proc_d      = 1'b0;
    best_key_d  = best_key_q;
    best_rank_d = best_rank_q;
    best_c_d    = best_c_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    plo_d       = plo_q;
    ecnt_d      = ecnt_q;
    out_valid   = 1'b0;
    out_item    = '0;

    if (better) begin
      best_key_d  = new_key;
      best_rank_d = new_rank;
      best_c_d    = cd_q;
    end

    case (state_q)
      ST_LOAD: begin
        if (s_acc) begin
          load_pos_d = load_pos_q + AW'(1);
          if (last_load) begin
            load_pos_d = '0;
            if (vnum > CW'(1)) begin
              in_tree_d    = '0;
              in_tree_d[0] = 1'b1;
              size_d       = CW'(1);
              u_d          = '0;
              r_d          = '0;
              base_d       = '0;
              first_d      = 1'b1;
              c_d          = '0;
              best_key_d   = WEIGHT_LIMIT;
              state_d      = ST_PASS;
            end
          end
        end
        if (cfg_valid_i) begin
          vcount_d   = cfg_data_i;
          load_pos_d = '0;
        end
      end
      ST_PASS: begin
        if (c_q < vnum) begin
          proc_d = 1'b1;
          c_d    = c_q + CW'(1);
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!found) begin
          out_valid             = 1'b1;
          out_item.last_edge    = 1'b1;
          out_item.disconnected = 1'b1;
          if (out_ready) begin
            state_d = ST_LOAD;
          end
        end else begin
          in_tree_d[best_c_q] = 1'b1;
          u_d     = best_c_q;
          r_d     = size_q[VW-1:0];
          size_d  = size_q + CW'(1);
          if (size_q + CW'(1) == vnum) begin
            lo_d    = '0;
            ecnt_d  = '0;
            state_d = ST_ROW_RD;
          end else begin
            base_d     = AW'(AW'(best_c_q) * AW'(vnum));
            c_d        = '0;
            first_d    = 1'b0;
            best_key_d = WEIGHT_LIMIT;
            state_d    = ST_PASS;
          end
        end
      end
      ST_ROW_RD: begin
        state_d = ST_ROW_CAP;
      end
      ST_ROW_CAP: begin
        plo_d   = rd_par;
        hi_d    = lo_q + VW'(1);
        state_d = ST_PAIR_RD;
      end
      ST_PAIR_RD: begin
        state_d = ST_PAIR_CHK;
      end
      ST_PAIR_CHK: begin
        if (edge_hit) begin
          out_valid            = 1'b1;
          out_item.low_vertex  = VNUM_W'((VW + 1)'(lo_q) + (VW + 1)'(1));
          out_item.high_vertex = VNUM_W'((VW + 1)'(hi_q) + (VW + 1)'(1));
          out_item.last_edge   = is_last;
        end
        if (!edge_hit || out_ready) begin
          if (edge_hit) begin
            ecnt_d = ecnt_q + CW'(1);
          end
          if (edge_hit && is_last) begin
            state_d = ST_LOAD;
          end else if (CW'(hi_q) == vnum - CW'(1)) begin
            lo_d    = lo_q + VW'(1);
            state_d = ST_ROW_RD;
          end else begin
            hi_d    = hi_q + VW'(1);
            state_d = ST_PAIR_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      vcount_q   <= VCOUNT_RST;
      load_pos_q <= '0;
      in_tree_q  <= '0;
      size_q     <= '0;
      first_q    <= 1'b0;
      c_q        <= '0;
      proc_q     <= 1'b0;
      ecnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      vcount_q   <= vcount_d;
      load_pos_q <= load_pos_d;
      in_tree_q  <= in_tree_d;
      size_q     <= size_d;
      first_q    <= first_d;
      c_q        <= c_d;
      proc_q     <= proc_d;
      ecnt_q     <= ecnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q         <= u_d;
    r_q         <= r_d;
    base_q      <= base_d;
    cd_q        <= c_q[VW-1:0];
    best_key_q  <= best_key_d;
    best_rank_q <= best_rank_d;
    best_c_q    <= best_c_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    plo_q       <= plo_d;
  end

  prim_mst_wgt_mem #(
    .DEPTH        (DEPTH),
    .WEIGHT_WIDTH (WEIGHT_WIDTH)
  ) u_wgt_mem (
    .clk_i   (clk_i),
    .we_i    (s_acc),
    .waddr_i (load_pos_q),
    .wdata_i (s_axis_tdata[WEIGHT_WIDTH-1:0]),
    .re_i    (wre),
    .raddr_i (base_q + AW'(c_q[VW-1:0])),
    .rdata_o (w_rd)
  );

  prim_mst_vtx_mem #(
    .DEPTH (MAX_VERTICES),
    .DW    (DW)
  ) u_vtx_mem (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (cd_q),
    .wdata_i (vwdata),
    .re_i    (vre),
    .raddr_i (vraddr),
    .rdata_o (vrd)
  );

  prim_mst_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (out_valid),
    .item_i        (out_item),
    .item_ready_o  (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ rtl/prim_mst_wgt_mem.sv @@
// ---------------------------------------------------------------------------
// prim_mst_wgt_mem
// weight matrix store, saturates unusable weights to the limit on write
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prim_mst_wgt_mem
  import prim_mst_pkg::*;
#(
  parameter int unsigned DEPTH        = 1024,
  parameter int unsigned WEIGHT_WIDTH = 14,
  parameter int unsigned AW           = $clog2(DEPTH)
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AW-1:0]           waddr_i,
  input  wire logic [WEIGHT_WIDTH-1:0] wdata_i,
  input  wire logic                    re_i,
  input  wire logic [AW-1:0]           raddr_i,
  output logic      [KEY_W-1:0]        rdata_o
);

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] wsat;

  always_comb begin
    if (wdata_i >= WEIGHT_WIDTH'(WEIGHT_LIMIT)) begin
      wsat = WEIGHT_LIMIT;
    end else begin
      wsat = wdata_i[KEY_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wsat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/prim_mst_vtx_mem.sv @@
// ---------------------------------------------------------------------------
// prim_mst_vtx_mem
// per-vertex record store: best key, parent and parent tree rank
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prim_mst_vtx_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned DW    = 24,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/prim_mst_out.sv @@
// ---------------------------------------------------------------------------
// prim_mst_out
// result register stage driving the master stream
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prim_mst_out
  import prim_mst_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   item_valid_i,
  input  wire out_item_t              item_i,
  output logic                        item_ready_o,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // low_vertex, high_vertex, zero pad
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser   // disconnected
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign item_ready_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (item_ready_o) begin
      valid_d = item_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      item_q <= item_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - 2 * VNUM_W)'(0), item_q.high_vertex, item_q.low_vertex};
  assign m_axis_tlast  = item_q.last_edge;
  assign m_axis_tuser  = item_q.disconnected;

endmodule

`default_nettype wire

@@ rtl/prim_mst_chk.sv @@
// ---------------------------------------------------------------------------
// prim_mst_chk
// port-level checks of the minimum spanning tree core, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "prim_minimum_spanning_tree_core_defines.svh"

module prim_mst_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // stalled result holds
  `PMST_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

  // disconnected result is zeroed and marked final
  `PMST_ASSERT_IMP(a_disc_shape, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == 16'h0000))

  // tree edges are 1-based and ordered
  `PMST_ASSERT_IMP(a_edge_order, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, (m_axis_tdata[5:0] != 6'd0) && (m_axis_tdata[5:0] < m_axis_tdata[11:6]))

  // no new matrix is taken while a non-final edge is being handed over
  `PMST_ASSERT_IMP(a_no_load_mid_out, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !s_axis_tready)

endmodule

bind prim_minimum_spanning_tree_core prim_mst_chk u_prim_mst_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the minimum spanning tree core. It writes the vertex count,
// streams weight matrices in row-major order and checks every tree edge and
// disconnected result against a scoreboard, which runs its own Prim pass
// from vertex 0 on each loaded matrix and queues the sorted edges it expects.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import prim_mst_pkg::*;

localparam int unsigned MAX_V = 32;

typedef enum int {
  W_UNIFORM,
  W_TIES,
  W_SPARSE,
  W_CORNERS
} weight_mix_e;

class mst_scoreboard;
  logic [VNUM_W-1:0] vcount;
  logic [KEY_W-1:0]  matrix [MAX_V*MAX_V];
  int unsigned       load_pos;
  out_item_t         edges_q [$];
  int                errors;

  function new();
    vcount   = VCOUNT_RST;
    load_pos = 0;
    errors   = 0;
  endfunction

  function int unsigned span();
    if (vcount == 0) return 1;
    if (vcount > MAX_V) return MAX_V;
    return vcount;
  endfunction

  function void note_config(logic [VNUM_W-1:0] val);
    vcount   = val;
    load_pos = 0;
  endfunction

  function void note_weight(logic [KEY_W-1:0] w);
    int unsigned v;
    v = span();
    if (load_pos < MAX_V*MAX_V) matrix[load_pos] = w;
    load_pos++;
    if (load_pos < v*v) return;
    load_pos = 0;
    if (v > 1) grow_tree(v);
  endfunction

  function void grow_tree(int unsigned v);
    bit          joined [MAX_V];
    bit          picked [MAX_V][MAX_V];
    int unsigned order [MAX_V];
    int unsigned size, best, bp, bc, p, lo, hi;
    bit          found, have;
    out_item_t   e, held;
    for (int i = 0; i < MAX_V; i++) begin
      joined[i] = 1'b0;
      order[i]  = 0;
      for (int j = 0; j < MAX_V; j++) picked[i][j] = 1'b0;
    end
    joined[0] = 1'b1;
    size = 1;
    for (int unsigned step = 0; step + 1 < v; step++) begin
      best  = WEIGHT_LIMIT;
      bp    = 0;
      bc    = 0;
      found = 1'b0;
      for (int unsigned t = 0; t < size; t++) begin
        p = order[t];
        for (int unsigned c = 0; c < v; c++) begin
          if (!joined[c] && matrix[p*v+c] < best) begin
            best  = matrix[p*v+c];
            bp    = p;
            bc    = c;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        e.low_vertex   = '0;
        e.high_vertex  = '0;
        e.last_edge    = 1'b1;
        e.disconnected = 1'b1;
        edges_q.insert(edges_q.size(), e);
        return;
      end
      joined[bc]    = 1'b1;
      order[size++] = bc;
      lo = (bp < bc) ? bp : bc;
      hi = (bp < bc) ? bc : bp;
      picked[lo][hi] = 1'b1;
    end
    have = 1'b0;
    for (int unsigned a = 0; a < v; a++) begin
      for (int unsigned b = a + 1; b < v; b++) begin
        if (picked[a][b]) begin
          if (have) edges_q.insert(edges_q.size(), held);
          held.low_vertex   = VNUM_W'(a + 1);
          held.high_vertex  = VNUM_W'(b + 1);
          held.last_edge    = 1'b0;
          held.disconnected = 1'b0;
          have = 1'b1;
        end
      end
    end
    if (have) begin
      held.last_edge = 1'b1;
      edges_q.insert(edges_q.size(), held);
    end
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [VNUM_W-1:0] lo, logic [VNUM_W-1:0] hi, logic last, logic disc);
    out_item_t want;
    if (edges_q.size() == 0) begin
      report($sformatf("unexpected edge %0d-%0d last %0b disc %0b", lo, hi, last, disc));
      return;
    end
    want = edges_q.pop_front();
    if (lo !== want.low_vertex)
      report($sformatf("low vertex %0d, want %0d", lo, want.low_vertex));
    if (hi !== want.high_vertex)
      report($sformatf("high vertex %0d, want %0d", hi, want.high_vertex));
    if (last !== want.last_edge)
      report($sformatf("last flag %0b, want %0b", last, want.last_edge));
    if (disc !== want.disconnected)
      report($sformatf("disconnected flag %0b, want %0b", disc, want.disconnected));
  endtask

  function bit pending();
    return edges_q.size() != 0;
  endfunction
endclass

module tb_top;

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [VNUM_W-1:0]       cfg_data_i    = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [15:0]             s_axis_tdata  = '0;  // weight
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;        // low_vertex, high_vertex
  logic                    m_axis_tlast;        // last_edge
  logic                    m_axis_tuser;        // disconnected

  mst_scoreboard sb;
  bit            calm     = 1'b0;
  bit            hold_req = 1'b0;
  int            sent     = 0;

  prim_minimum_spanning_tree_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random backpressure plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 1200;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tlast, m_axis_tuser);
  end

  function automatic logic [KEY_W-1:0] pick_weight(weight_mix_e mix);
    case (mix)
      W_UNIFORM: return KEY_W'($urandom_range(0, 16383));
      W_TIES:    return KEY_W'($urandom_range(0, 7));
      W_SPARSE: begin
        if ($urandom_range(0, 9) < 8) return KEY_W'($urandom_range(10000, 16383));
        return KEY_W'($urandom_range(0, 9999));
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return KEY_W'(9999);
          2:       return WEIGHT_LIMIT;
          3:       return '1;
          default: return KEY_W'($urandom_range(0, 16383));
        endcase
      end
    endcase
  endfunction

  task automatic send_weight(logic [KEY_W-1:0] w);
    while (!calm && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, w};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_weight(w);
    sent++;
  endtask

  task automatic send_matrix(weight_mix_e mix);
    int unsigned total;
    total = sb.span() * sb.span();
    repeat (total) send_weight(pick_weight(mix));
  endtask

  // drain all expected edges, then let the output scan run out
  task automatic settle();
    int unsigned v;
    s_axis_tvalid <= 1'b0;
    while (sb.pending()) @(posedge clk_i);
    v = sb.span();
    repeat (3*v*v + 64) @(posedge clk_i);
  endtask

  task automatic write_vcount(logic [VNUM_W-1:0] val);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.note_config(val);
  endtask

  initial begin
    logic [VNUM_W-1:0] val;
    int                blk, nmat, base, total;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero count acts as one vertex: absorbed, nothing emitted
    write_vcount('0);
    send_weight('1);
    // two vertices, largest usable weight
    write_vcount(6'd2);
    send_weight('0);
    send_weight(KEY_W'(9999));
    send_weight(WEIGHT_LIMIT);
    send_weight('0);
    // two vertices, only edge at the limit
    send_weight('0);
    send_weight(WEIGHT_LIMIT);
    send_weight('0);
    send_weight('1);
    // count rewritten mid-load restarts the load
    send_weight('1);
    send_weight('1);
    write_vcount(6'd3);
    // all weights equal: ties resolved by tree order then child index
    repeat (9) send_weight(KEY_W'(5));

    base = sent;
    blk  = 0;
    while (sent < base + 370) begin
      calm = (blk == 1 || blk == 2);
      if (blk == 0) begin
        val = 6'd4;
      end else begin
        case ($urandom_range(0, 9))
          0:       val = VNUM_W'($urandom_range(0, 1));
          9:       val = VNUM_W'($urandom_range(7, 10));
          default: val = VNUM_W'($urandom_range(2, 6));
        endcase
      end
      write_vcount(val);
      total = sb.span() * sb.span();
      if (total > 1 && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, total - 1)) send_weight(pick_weight(weight_mix_e'($urandom_range(0, 3))));
        write_vcount(val);
      end
      nmat = (blk == 0) ? 10 : $urandom_range(1, 6);
      if (blk == 0) hold_req = 1'b1;
      repeat (nmat) begin
        if (sent < base + 370) send_matrix(weight_mix_e'($urandom_range(0, 3)));
      end
      blk++;
    end
    calm = 1'b0;

    // count above the maximum, load cut short by a rewrite
    write_vcount(6'd63);
    repeat (5) send_weight(pick_weight(weight_mix_e'($urandom_range(0, 3))));
    write_vcount(6'd2);
    send_matrix(weight_mix_e'($urandom_range(0, 3)));

    settle();
    if (sb.errors == 0 && !sb.pending())
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/prim_mst_pkg.sv
rtl/prim_mst_wgt_mem.sv
rtl/prim_mst_vtx_mem.sv
rtl/prim_mst_out.sv
rtl/prim_minimum_spanning_tree_core.sv
rtl/prim_mst_chk.sv
test/tb_top.sv
